@@ sv/tmf_pkg.sv @@
// Shared types, constants and sort helpers for the 3x3 trimmed-mean filter.
// Used by trimmed_mean_filter_3x3_top and tmf_rank_mean; depends on nothing.
`default_nettype none

package tmf_pkg;

    // Pixel and register widths
    localparam int PIX_W     = 8;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;

    // Register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    // Register reset values and height clamp
    localparam logic [CFG_W-1:0] IMAGE_WIDTH_RST  = 11'd640;
    localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RST = 11'd480;
    localparam logic [CFG_W-1:0] HEIGHT_LIMIT     = 11'd1024;

    // Sum of three ranks and division by three as (sum * 683) >> 11
    localparam int               SUM_W      = 10;
    localparam int               PROD_W     = 2 * SUM_W;
    localparam logic [SUM_W-1:0] DIV3_MUL   = 10'd683;
    localparam int               DIV3_SHIFT = 11;

    typedef logic [PIX_W-1:0]         t_pix;
    typedef logic [2:0][PIX_W-1:0]    t_col;    // [0] top, [1] middle, [2] bottom
    typedef logic [8:0][PIX_W-1:0]    t_win9;

    // Control carried alongside a window through the rank pipeline
    typedef struct packed {
        logic valid;
        logic last;
    } t_tag;

    // One round of odd-even transposition sort over nine values
    function automatic t_win9 oet_round(input t_win9 v, input logic odd);
        t_win9 r;
        r = v;
        for (int i = 0; i < 8; i++) begin
            if ((i[0] == odd) && (v[i] > v[i+1])) begin
                r[i]   = v[i+1];
                r[i+1] = v[i];
            end
        end
        return r;
    endfunction

    // Three consecutive rounds with alternating parity
    function automatic t_win9 oet_three(input t_win9 v, input logic odd_first);
        t_win9 r;
        r = oet_round(v, odd_first);
        r = oet_round(r, !odd_first);
        r = oet_round(r, odd_first);
        return r;
    endfunction

endpackage

`default_nettype wire

@@ sv/tmf_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module tmf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ sv/tmf_rank_mean.sv @@
// Rank pipeline: sorts a 3x3 window over three stages and averages ranks 4..6.
// Depends on tmf_pkg (window types, sort rounds, divide-by-three constants).
`default_nettype none

module tmf_rank_mean
    import tmf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_adv,      // whole pipeline moves one step
    input  t_tag  i_tag,
    input  t_win9 i_win,
    output t_tag  o_tag,
    output t_pix  o_mean
);

    t_tag              r_tag [5];
    t_win9             r_win0;
    t_win9             r_win1;
    t_win9             r_win2;
    logic [SUM_W-1:0]  r_sum;
    t_pix              r_mean;

    t_win9             sorted;
    logic [SUM_W-1:0]  n_sum;
    logic [PROD_W-1:0] prod;

    // Last three sort rounds, then the middle three ranks summed
    always_comb begin
        sorted = oet_three(r_win2, 1'b0);
        n_sum  = SUM_W'(sorted[3]) + SUM_W'(sorted[4]) + SUM_W'(sorted[5]);
    end

    // Divide by three through the reciprocal
    assign prod = PROD_W'(r_sum) * PROD_W'(DIV3_MUL);

    // Valid/last travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 5; i++) begin
                r_tag[i] <= '0;
            end
        end else if (i_adv) begin
            r_tag[0] <= i_tag;
            for (int i = 1; i < 5; i++) begin
                r_tag[i] <= r_tag[i-1];
            end
        end
    end

    // Data stages
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_win0 <= i_win;
            r_win1 <= oet_three(r_win0, 1'b0);
            r_win2 <= oet_three(r_win1, 1'b1);
            r_sum  <= n_sum;
            r_mean <= prod[DIV3_SHIFT +: PIX_W];
        end
    end

    assign o_tag  = r_tag[4];
    assign o_mean = r_mean;

endmodule

`default_nettype wire

@@ sv/trimmed_mean_filter_3x3_top.sv @@
// Top level of the streaming 3x3 trimmed-mean filter.
// Depends on tmf_pkg, tmf_ram (line memory) and tmf_rank_mean (sort and average).
`default_nettype none

// Takes one pixel per clock in raster order and returns, for each pixel, the
// truncated mean of the 4th..6th smallest values of its 3x3 neighborhood, with
// edge pixels replicated at the borders. Result n leaves with input transfer
// n + W + 1; after the last pixel, W + 1 drain transfers (tuser set) flush the
// rest and the last result carries tlast. Drain transfers sent while pixels
// are still expected are dropped. One transfer per clock is sustained: the two
// previous lines sit in one line memory that is read and written back once
// per pixel, with the write forwarded when the next pixel hits the same
// column. A result passes stage 1, the rank pipeline and the output register
// before it is on m_axis. s_axis_tready is registered and drops only when
// both the output register and the skid register hold results. A register
// write restarts the frame; the line memory needs no clear after reset.
module trimmed_mean_filter_3x3_top
    import tmf_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    // pixel input
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [PIX_W-1:0]     s_axis_tdata,   // [7:0] pixel
    input  logic [0:0]           s_axis_tuser,   // [0] drain
    // filtered output
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [PIX_W-1:0]     m_axis_tdata,   // [7:0] filtered_pixel
    output logic                 m_axis_tlast    // frame_last
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int CW = (WW > CFG_W) ? WW : CFG_W;

    // ---------------- registers ----------------
    logic [CFG_W-1:0]   r_cfg_w;
    logic [CFG_W-1:0]   r_cfg_h;
    logic [AW-1:0]      r_col;
    logic [CFG_W-1:0]   r_row;

    logic               r_s1_valid;
    logic [AW-1:0]      r_s1_col;
    logic               r_s1_top_sel;
    logic               r_s1_real;
    logic               r_s1_first;
    logic               r_s1_emit;
    logic               r_s1_last;
    t_pix               r_s1_pix;
    logic               r_fwd_hit;
    logic [2*PIX_W-1:0] r_fwd_data;

    t_col               r_win_c1;
    t_col               r_win_c2;

    logic               r_out_valid;
    t_pix               r_out_data;
    logic               r_out_last;
    logic               r_skid_valid;
    t_pix               r_skid_data;
    logic               r_skid_last;

    // ---------------- combinational ----------------
    logic [CW-1:0]      cfg_w_ext;
    logic [CW-1:0]      eff_w;
    logic [CFG_W-1:0]   eff_h;
    logic               cfg_wr;
    logic               adv;
    logic               acc;
    logic               is_real;
    logic               take_item;
    logic               row_ge2;
    logic               col0;
    logic               emit;
    logic               last;
    logic [CW-1:0]      col_inc;
    logic               wrap;
    logic [AW-1:0]      n_col;
    logic [CFG_W-1:0]   n_row;

    logic               ram_we;
    logic [2*PIX_W-1:0] ram_wdata;
    logic [2*PIX_W-1:0] ram_rdata;
    logic [2*PIX_W-1:0] ram_q;
    t_pix               up_q;
    t_pix               mid_q;
    t_col               new_col;
    t_win9              sort_in;
    t_tag               rk_in_tag;
    t_tag               rk_tag;
    t_pix               rk_mean;
    logic               push;
    logic               take;

    // Effective frame size with out-of-range values clamped
    always_comb begin
        cfg_w_ext = CW'(r_cfg_w);
        if (cfg_w_ext == '0) begin
            eff_w = CW'(1);
        end else if (cfg_w_ext > CW'(MAX_WIDTH)) begin
            eff_w = CW'(MAX_WIDTH);
        end else begin
            eff_w = cfg_w_ext;
        end
        if (r_cfg_h == '0) begin
            eff_h = CFG_W'(1);
        end else if (r_cfg_h > HEIGHT_LIMIT) begin
            eff_h = HEIGHT_LIMIT;
        end else begin
            eff_h = r_cfg_h;
        end
    end

    // Configuration channel
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && ((i_cfg_index == REG_IMAGE_WIDTH) ||
                                         (i_cfg_index == REG_IMAGE_HEIGHT));

    // Input handshake; the pipeline moves whenever the skid register is free
    assign adv           = !r_skid_valid;
    assign s_axis_tready = adv;
    assign acc           = s_axis_tvalid && adv;

    // Position decode for the incoming transfer
    always_comb begin
        is_real   = r_row < eff_h;
        take_item = acc && !(is_real && s_axis_tuser[0]);
        row_ge2   = r_row >= CFG_W'(2);
        col0      = r_col == '0;
        emit      = row_ge2 || ((r_row == CFG_W'(1)) && !col0);
        last      = emit && col0 && (r_row == (eff_h + CFG_W'(1)));
        col_inc   = CW'(r_col) + CW'(1);
        wrap      = col_inc >= eff_w;
        if (last) begin
            n_col = '0;
            n_row = '0;
        end else if (wrap) begin
            n_col = '0;
            n_row = r_row + CFG_W'(1);
        end else begin
            n_col = col_inc[AW-1:0];
            n_row = r_row;
        end
    end

    // Config registers and frame position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= IMAGE_WIDTH_RST;
            r_cfg_h <= IMAGE_HEIGHT_RST;
            r_col   <= '0;
            r_row   <= '0;
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                REG_IMAGE_WIDTH:  r_cfg_w <= i_cfg_data;
                REG_IMAGE_HEIGHT: r_cfg_h <= i_cfg_data;
                default: ;
            endcase
            r_col <= '0;
            r_row <= '0;
        end else if (take_item) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Line memory: {upper line, middle line} per column
    tmf_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_s1_col),
        .i_wdata (ram_wdata),
        .i_re    (take_item),
        .i_raddr (r_col),
        .o_rdata (ram_rdata)
    );

    // Stage 1 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= take_item;
        end
    end

    // Stage 1 payload and write forwarding for a same-column successor
    always_ff @(posedge i_clk) begin
        if (take_item) begin
            r_s1_col     <= r_col;
            r_s1_top_sel <= row_ge2;
            r_s1_real    <= is_real;
            r_s1_first   <= col0;
            r_s1_emit    <= emit;
            r_s1_last    <= last;
            r_s1_pix     <= s_axis_tdata;
            r_fwd_hit    <= ram_we && (r_s1_col == r_col);
            r_fwd_data   <= ram_wdata;
        end
    end

    // New window column from memory data and the incoming pixel
    always_comb begin
        ram_q      = r_fwd_hit ? r_fwd_data : ram_rdata;
        up_q       = ram_q[2*PIX_W-1:PIX_W];
        mid_q      = ram_q[PIX_W-1:0];
        new_col[0] = r_s1_top_sel ? up_q : mid_q;
        new_col[1] = mid_q;
        new_col[2] = r_s1_real ? r_s1_pix : mid_q;
        ram_we     = r_s1_valid && adv;
        ram_wdata  = {new_col[1], new_col[2]};
        // first column closes the previous line with its right edge repeated
        sort_in    = r_s1_first ? {r_win_c2, r_win_c2, r_win_c1}
                                : {new_col, r_win_c2, r_win_c1};
        rk_in_tag.valid = r_s1_valid && r_s1_emit;
        rk_in_tag.last  = r_s1_last;
    end

    // Two newest window columns; a new line starts with its left edge repeated
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_c1 <= '0;
            r_win_c2 <= '0;
        end else if (ram_we) begin
            if (r_s1_first) begin
                r_win_c1 <= new_col;
                r_win_c2 <= new_col;
            end else begin
                r_win_c1 <= r_win_c2;
                r_win_c2 <= new_col;
            end
        end
    end

    tmf_rank_mean u_rank (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_tag   (rk_in_tag),
        .i_win   (sort_in),
        .o_tag   (rk_tag),
        .o_mean  (rk_mean)
    );

    // Output register with skid register
    assign push = adv && rk_tag.valid;
    assign take = r_out_valid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (push) begin
            if (!r_out_valid || take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (take) begin
                r_out_data <= r_skid_data;
                r_out_last <= r_skid_last;
            end
        end else if (push) begin
            if (!r_out_valid || take) begin
                r_out_data <= rk_mean;
                r_out_last <= rk_tag.last;
            end else begin
                r_skid_data <= rk_mean;
                r_skid_last <= rk_tag.last;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

    // ---------------- assertions ----------------
    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds a result while output register is empty");

    a_col_in_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(r_col) < eff_w)
        else $error("column counter beyond line width");

    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= (eff_h + CFG_W'(1)))
        else $error("row counter beyond flush line");

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take_item && last) |=> ((r_row == '0) && (r_col == '0)))
        else $error("frame position not cleared after last result");

endmodule

`default_nettype wire
